// ----- hdl/ilbs_pkg.sv -----
// Shared types and constants for the icon list best-size selector.
`timescale 1ns / 1ps

package ilbs_pkg;

    // Field widths of the stream items and the register
    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned OUT_INDEX_BITS = 24;
    localparam int unsigned DEF_INDEX_BITS = 24;
    localparam int unsigned S_TDATA_BITS   = WORD_BITS;
    localparam int unsigned M_TDATA_BITS   = OUT_INDEX_BITS + WORD_BITS;

    // Outcome of judging one complete record
    typedef struct packed {
        logic take;   // record replaces the current best
        logic exact;  // record width equals the target, search ends
    } decision_t;

endpackage

// ----- hdl/ilbs_judge.sv -----
// Selection rule applied to one complete record against the current best.
`timescale 1ns / 1ps

module ilbs_judge (
    input  logic [ilbs_pkg::WORD_BITS-1:0] rec_width,
    input  logic [ilbs_pkg::WORD_BITS-1:0] target_size,
    input  logic [ilbs_pkg::WORD_BITS-1:0] best_size,
    input  logic                           exact_done,
    output ilbs_pkg::decision_t            decision
);
    import ilbs_pkg::*;

    logic is_exact;
    logic is_above;
    logic above_ok;
    logic below_ok;

    // Compare the width to the target and to the best so far
    always_comb begin
        is_exact = (rec_width == target_size);
        is_above = (rec_width > target_size);
        above_ok = !((best_size > target_size) && (rec_width >= best_size));
        below_ok = (rec_width > best_size);
        decision.exact = !exact_done && is_exact;
        decision.take  = !exact_done &&
                         (is_exact || (is_above ? above_ok : below_ok));
    end

endmodule

// ----- hdl/icon_list_best_size_select.sv -----
// Top level of the icon list best-size selector: record parser, best tracker, result register.
//
//  channel   direction  payload
//  s_*       in         tdata = word[31:0], tlast = last
//  m_*       out        tdata = best_index[23:0], best_width[55:24]; tuser = found
//  cfg_*     in         cfg_wdata = target_size[31:0], written when cfg_we is high
//
// One list word is taken every cycle while s_tready is high; the 32x32 pixel-count multiply
// on the height word and the 64-bit pixel countdown each sit between the state registers.
// A result appears in the cycle after the item carrying tlast is taken and waits in the output
// register; s_tready stays high while that register is empty or being taken.
// aresetn (synchronous, active low) returns the list state and target_size to zero.
`timescale 1ns / 1ps

module icon_list_best_size_select #(
    parameter int unsigned INDEX_BITS = ilbs_pkg::DEF_INDEX_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration register target_size
    input  logic                              cfg_we,
    input  logic [ilbs_pkg::WORD_BITS-1:0]    cfg_wdata,
    // input items: tdata = word
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ilbs_pkg::S_TDATA_BITS-1:0] s_tdata,   // [31:0] word
    input  logic                              s_tlast,   // last
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ilbs_pkg::M_TDATA_BITS-1:0] m_tdata,   // [23:0] best_index, [55:24] best_width
    output logic                              m_tuser    // found
);
    import ilbs_pkg::*;

    typedef enum logic [1:0] {
        PH_WIDTH,
        PH_HEIGHT,
        PH_PIXELS
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [INDEX_BITS-1:0]   position_reg, position_next;
    logic [INDEX_BITS-1:0]   rec_start_reg, rec_start_next;
    logic [WORD_BITS-1:0]    rec_width_reg, rec_width_next;
    logic [2*WORD_BITS-1:0]  pixels_reg, pixels_next;
    logic [WORD_BITS-1:0]    best_size_reg, best_size_next;
    logic [INDEX_BITS-1:0]   best_start_reg, best_start_next;
    logic                    have_best_reg, have_best_next;
    logic                    exact_done_reg, exact_done_next;
    logic [WORD_BITS-1:0]    target_reg;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [M_TDATA_BITS-1:0] m_data_reg, m_data_next;

    logic                    accept;
    logic                    judge_en;
    logic [WORD_BITS-1:0]    word;
    logic [31:0]             start_ext;
    decision_t               decision;

    assign word     = s_tdata[WORD_BITS-1:0];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ilbs_judge u_judge (
        .rec_width   (rec_width_reg),
        .target_size (target_reg),
        .best_size   (best_size_reg),
        .exact_done  (exact_done_reg),
        .decision    (decision)
    );

    // Parse records, update the best record and load the result on the last item
    always_comb begin
        phase_next      = phase_reg;
        position_next   = position_reg;
        rec_start_next  = rec_start_reg;
        rec_width_next  = rec_width_reg;
        pixels_next     = pixels_reg;
        best_size_next  = best_size_reg;
        best_start_next = best_start_reg;
        have_best_next  = have_best_reg;
        exact_done_next = exact_done_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_found_next    = m_found_reg;
        m_data_next     = m_data_reg;
        judge_en        = 1'b0;
        start_ext       = '0;

        if (accept) begin
            case (phase_reg)
                PH_HEIGHT: begin
                    pixels_next = {{WORD_BITS{1'b0}}, rec_width_reg} *
                                  {{WORD_BITS{1'b0}}, word};
                    if (rec_width_reg == '0 || word == '0) begin
                        judge_en   = 1'b1;
                        phase_next = PH_WIDTH;
                    end else begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    pixels_next = pixels_reg - {{(2*WORD_BITS-1){1'b0}}, 1'b1};
                    if (pixels_reg == {{(2*WORD_BITS-1){1'b0}}, 1'b1}) begin
                        judge_en   = 1'b1;
                        phase_next = PH_WIDTH;
                    end
                end
                default: begin
                    rec_start_next = position_reg;
                    rec_width_next = word;
                    phase_next     = PH_HEIGHT;
                end
            endcase
            position_next = position_reg + {{(INDEX_BITS-1){1'b0}}, 1'b1};

            // Take the completed record if the rule says so
            if (judge_en && decision.take) begin
                best_size_next  = rec_width_reg;
                best_start_next = rec_start_reg;
                have_best_next  = 1'b1;
                if (decision.exact) begin
                    exact_done_next = 1'b1;
                end
            end

            // Report on the last item, then start a fresh list
            if (s_tlast) begin
                start_ext    = 32'(best_start_next);
                m_valid_next = 1'b1;
                m_found_next = have_best_next;
                if (have_best_next) begin
                    m_data_next = {best_size_next, start_ext[OUT_INDEX_BITS-1:0]};
                end else begin
                    m_data_next = '0;
                end
                phase_next      = PH_WIDTH;
                position_next   = '0;
                rec_start_next  = '0;
                rec_width_next  = '0;
                pixels_next     = '0;
                best_size_next  = '0;
                best_start_next = '0;
                have_best_next  = 1'b0;
                exact_done_next = 1'b0;
            end
        end
    end

    // Hold list state, target and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WIDTH;
            position_reg   <= '0;
            rec_start_reg  <= '0;
            rec_width_reg  <= '0;
            pixels_reg     <= '0;
            best_size_reg  <= '0;
            best_start_reg <= '0;
            have_best_reg  <= 1'b0;
            exact_done_reg <= 1'b0;
            target_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            rec_start_reg  <= rec_start_next;
            rec_width_reg  <= rec_width_next;
            pixels_reg     <= pixels_next;
            best_size_reg  <= best_size_next;
            best_start_reg <= best_start_next;
            have_best_reg  <= have_best_next;
            exact_done_reg <= exact_done_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
        end
        m_found_reg <= m_found_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_data_reg;

endmodule
